### hdl/rgb_to_hsl_converter_defines.svh
// Assertion macros shared by the converter RTL.
`ifndef RGB_TO_HSL_CONVERTER_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
`define HSL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rgb_to_hsl_converter assertion failed");
`define HSL_ASSERT_VLD(lbl, cond) `HSL_ASSERT(lbl, out_valid_o |-> (cond))
`else
`define HSL_ASSERT(lbl, prop)
`define HSL_ASSERT_VLD(lbl, cond)
`endif

`endif

### hdl/hsl_pkg.sv
package hsl_pkg;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned HUE_INT_W = 9;
  localparam int unsigned NUM_W     = 11;
  localparam int unsigned LIGHT_W   = 9;

  localparam logic [LIGHT_W-1:0] LIGHT_MAX = 9'd510;
  localparam logic [LIGHT_W-1:0] LIGHT_MID = 9'd255;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

endpackage

### hdl/hsl_prep.sv
module hsl_prep import hsl_pkg::*; #(
  parameter int unsigned HUE_FRAC_BITS = 6,
  parameter int unsigned SAT_BITS      = 16
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [CH_W-1:0]                       red_i,
  input  logic [CH_W-1:0]                       green_i,
  input  logic [CH_W-1:0]                       blue_i,
  output logic [CH_W-1:0]                       sat_rem_o,
  output logic [SAT_BITS-1:0]                   sat_low_o,
  output logic [CH_W-1:0]                       sat_div_o,
  output logic [CH_W-1:0]                       hue_rem_o,
  output logic [HUE_INT_W+HUE_FRAC_BITS-1:0]    hue_low_o,
  output logic [CH_W-1:0]                       hue_div_o,
  output logic [LIGHT_W-1:0]                    light_o
);

  localparam int unsigned HUE_W = HUE_INT_W + HUE_FRAC_BITS;
  localparam int unsigned SN_W  = CH_W + SAT_BITS;
  localparam int unsigned HN_W  = CH_W + HUE_W;
  localparam int unsigned PR_W  = NUM_W + 6;

  // stage 1: max, min and sector
  logic [CH_W-1:0] r_q, g_q, b_q, mx_q, mn_q;
  logic [CH_W-1:0] mx_d, mn_d;
  sector_e         sec_q, sec_d;

  always_comb begin
    mx_d  = red_i;
    sec_d = SEC_RED;
    if (green_i > mx_d) begin
      mx_d  = green_i;
      sec_d = SEC_GREEN;
    end
    if (blue_i > mx_d) begin
      mx_d  = blue_i;
      sec_d = SEC_BLUE;
    end
    mn_d = red_i;
    if (green_i < mn_d) mn_d = green_i;
    if (blue_i < mn_d) mn_d = blue_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q   <= red_i;
      g_q   <= green_i;
      b_q   <= blue_i;
      mx_q  <= mx_d;
      mn_q  <= mn_d;
      sec_q <= sec_d;
    end
  end

  // stage 2: spread, sum, divisors and sector numerator
  logic [CH_W-1:0]    d_w;
  logic [LIGHT_W-1:0] sum_d, sum_q, den_full;
  logic [CH_W-1:0]    den_d, den_q, dd_d, dd_q;
  logic [NUM_W-1:0]   num_d, num_q, d_n;
  logic [CH_W-1:0]    d_q;

  always_comb begin
    d_w      = mx_q - mn_q;
    sum_d    = LIGHT_W'(mx_q) + LIGHT_W'(mn_q);
    den_full = (sum_d >= LIGHT_MID) ? (LIGHT_MAX - sum_d) : sum_d;
    // drop a zero divisor: a grey pixel then yields zero quotients
    den_d    = (d_w == '0) ? CH_W'(1) : den_full[CH_W-1:0];
    dd_d     = (d_w == '0) ? CH_W'(1) : d_w;
    d_n      = NUM_W'(d_w);
    unique case (sec_q)
      SEC_RED: begin
        if (g_q >= b_q) num_d = NUM_W'(g_q) - NUM_W'(b_q);
        else num_d = NUM_W'(6) * d_n - (NUM_W'(b_q) - NUM_W'(g_q));
      end
      SEC_GREEN: num_d = (d_n << 1) + NUM_W'(b_q) - NUM_W'(r_q);
      default:   num_d = (d_n << 2) + NUM_W'(r_q) - NUM_W'(g_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q   <= d_w;
      sum_q <= sum_d;
      den_q <= den_d;
      dd_q  <= dd_d;
      num_q <= num_d;
    end
  end

  // stage 3: dividends, split into initial remainder and shifted bits
  logic [SN_W-1:0] sat_n;
  logic [PR_W-1:0] num60;
  logic [HN_W-1:0] hue_n;

  always_comb begin
    sat_n = (SN_W'(d_q) << SAT_BITS) - SN_W'(d_q);
    num60 = (PR_W'(num_q) << 6) - (PR_W'(num_q) << 2);
    hue_n = HN_W'(num60) << HUE_FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_rem_o <= sat_n[SN_W-1 -: CH_W];
      sat_low_o <= sat_n[SAT_BITS-1:0];
      sat_div_o <= den_q;
      hue_rem_o <= hue_n[HN_W-1 -: CH_W];
      hue_low_o <= hue_n[HUE_W-1:0];
      hue_div_o <= dd_q;
      light_o   <= sum_q;
    end
  end

endmodule

### hdl/hsl_div_stage.sv
module hsl_div_stage import hsl_pkg::*; #(
  parameter int unsigned LOW_W  = 16,
  parameter bit          ACTIVE = 1'b1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [CH_W-1:0]  rem_i,
  input  logic [LOW_W-1:0] low_i,
  input  logic [CH_W-1:0]  div_i,
  output logic [CH_W-1:0]  rem_o,
  output logic [LOW_W-1:0] low_o,
  output logic [CH_W-1:0]  div_o
);

  // when ACTIVE, one restoring step: a dividend bit down, a quotient bit in
  logic [CH_W:0]    trial, diff;
  logic             ge;
  logic [CH_W-1:0]  rem_d;
  logic [LOW_W-1:0] low_d;

  always_comb begin
    trial = {rem_i, low_i[LOW_W-1]};
    diff  = trial - {1'b0, div_i};
    ge    = (trial >= {1'b0, div_i});
    if (ACTIVE) begin
      rem_d = ge ? diff[CH_W-1:0] : trial[CH_W-1:0];
      low_d = {low_i[LOW_W-2:0], ge};
    end else begin
      rem_d = rem_i;
      low_d = low_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      low_o <= low_d;
      div_o <= div_i;
    end
  end

endmodule

### hdl/rgb_to_hsl_converter.sv
// RGB to HSL converter, fully pipelined.
// Input channel: in_valid_i / in_stall_o with red_i, green_i, blue_i; a pixel
// transfers on a rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with hue_o (1/2^HUE_FRAC_BITS
// degree units), saturation_o (times 2^SAT_BITS-1) and lightness_o (max+min).
// Three front stages find max/min, sector, divisors and dividends; then each
// divider stage yields one quotient bit of each of the saturation and hue
// divisions that is still active; the shorter one idles in its last stages.
// Throughput: one pixel per clock while the output is not stalled, set by
// one restoring step per stage. A stall on the output while out_valid_o is
// high freezes every stage together: in_stall_o rises in the same cycle, no
// pixel is lost or repeated, and bubbles simply travel.
// Reset clears only the valid bits; data registers need none.
module rgb_to_hsl_converter import hsl_pkg::*; #(
  parameter int unsigned HUE_FRAC_BITS = 6,
  parameter int unsigned SAT_BITS      = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [CH_W-1:0]                    red_i,
  input  logic [CH_W-1:0]                    green_i,
  input  logic [CH_W-1:0]                    blue_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [HUE_INT_W+HUE_FRAC_BITS-1:0] hue_o,
  output logic [SAT_BITS-1:0]                saturation_o,
  output logic [LIGHT_W-1:0]                 lightness_o
);

`include "rgb_to_hsl_converter_defines.svh"

  localparam int unsigned HUE_W = HUE_INT_W + HUE_FRAC_BITS;
  localparam int unsigned NDIV  = (SAT_BITS > HUE_W) ? SAT_BITS : HUE_W;
  localparam int unsigned NST   = 3 + NDIV;
  localparam logic [HUE_W-1:0] HUE_LIMIT = HUE_W'(360 << HUE_FRAC_BITS);

  // advance the whole pipe unless a finished result is held by the receiver
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic [NST-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[NST-1];

  logic [CH_W-1:0]     sat_rem [NDIV+1];
  logic [SAT_BITS-1:0] sat_low [NDIV+1];
  logic [CH_W-1:0]     sat_div [NDIV+1];
  logic [CH_W-1:0]     hue_rem [NDIV+1];
  logic [HUE_W-1:0]    hue_low [NDIV+1];
  logic [CH_W-1:0]     hue_div [NDIV+1];
  logic [LIGHT_W-1:0]  light_q [NDIV+1];

  hsl_prep #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS),
    .SAT_BITS     (SAT_BITS)
  ) u_prep (
    .clk_i    (clk_i),
    .en_i     (en),
    .red_i    (red_i),
    .green_i  (green_i),
    .blue_i   (blue_i),
    .sat_rem_o(sat_rem[0]),
    .sat_low_o(sat_low[0]),
    .sat_div_o(sat_div[0]),
    .hue_rem_o(hue_rem[0]),
    .hue_low_o(hue_low[0]),
    .hue_div_o(hue_div[0]),
    .light_o  (light_q[0])
  );

  // the shorter division idles through its trailing stages
  for (genvar i = 0; i < NDIV; i++) begin : g_div
    hsl_div_stage #(
      .LOW_W (SAT_BITS),
      .ACTIVE(i < SAT_BITS)
    ) u_sat (
      .clk_i(clk_i),
      .en_i (en),
      .rem_i(sat_rem[i]),
      .low_i(sat_low[i]),
      .div_i(sat_div[i]),
      .rem_o(sat_rem[i+1]),
      .low_o(sat_low[i+1]),
      .div_o(sat_div[i+1])
    );

    hsl_div_stage #(
      .LOW_W (HUE_W),
      .ACTIVE(i < HUE_W)
    ) u_hue (
      .clk_i(clk_i),
      .en_i (en),
      .rem_i(hue_rem[i]),
      .low_i(hue_low[i]),
      .div_i(hue_div[i]),
      .rem_o(hue_rem[i+1]),
      .low_o(hue_low[i+1]),
      .div_o(hue_div[i+1])
    );

    // carry lightness alongside the quotients
    always_ff @(posedge clk_i) begin
      if (en) begin
        light_q[i+1] <= light_q[i];
      end
    end
  end

  assign hue_o        = hue_low[NDIV];
  assign saturation_o = sat_low[NDIV];
  assign lightness_o  = light_q[NDIV];

  `HSL_ASSERT_VLD(a_hue_range, hue_o < HUE_LIMIT)
  `HSL_ASSERT_VLD(a_black_grey, (lightness_o != '0) || (saturation_o == '0 && hue_o == '0))
  `HSL_ASSERT_VLD(a_white_grey, (lightness_o != LIGHT_MAX) || (saturation_o == '0 && hue_o == '0))
  `HSL_ASSERT(a_stall_src, in_stall_o |-> (out_valid_o && out_stall_i))

endmodule
